### rtl/assert_macros.svh
// assertion macros shared by the datapath and top-level rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define BALE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define BALE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/bale_pkg.sv
// shared codes and controller/datapath interface types of the list engine
package bale_pkg;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_RMIDX  = 3'd2;
  localparam logic [2:0] CMD_RMVAL  = 3'd3;
  localparam logic [2:0] CMD_ADD    = 3'd4;
  localparam logic [2:0] CMD_SUB    = 3'd5;
  localparam logic [2:0] CMD_MUL    = 3'd6;
  localparam logic [2:0] CMD_DIV    = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_DIVZERO  = 3'd5;

  localparam logic [8:0] CAPACITY_RESET = 9'd256;

  typedef struct packed {
    logic load;
    logic decide;
    logic append;
    logic capture;
    logic div_start;
    logic div_take;
    logic write;
    logic finish;
    logic out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic err;
    logic is_append;
    logic is_read;
    logic is_div;
    logic loop_end;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/bale_ram.sv
// generic single write port ram with registered read
module bale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bale_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module bale_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] quo;
  logic [31:0] dsr;
  logic [32:0] rem;
  logic [32:0] rem_sh;
  logic [32:0] rem_next;
  logic        qbit;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;

  always_comb begin
    rem_sh   = {rem[31:0], quo[31]};
    qbit     = rem_sh >= {1'b0, dsr};
    rem_next = qbit ? rem_sh - {1'b0, dsr} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[31] ? -dividend : dividend;
      dsr <= divisor[31] ? -divisor : divisor;
      rem <= '0;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[30:0], qbit};
    end
  end

  assign quotient = neg ? -quo : quo;

endmodule

### rtl/bale_dp.sv
// list engine datapath: entry ram, count, pointers, arithmetic and result register
`include "assert_macros.svh"
module bale_dp #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [8:0]        cfg_data,
  input  logic [2:0]        command,
  input  logic [7:0]        index,
  input  logic [31:0]       value,
  input  bale_pkg::dp_ctl_t ctl,
  output bale_pkg::dp_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [31:0]       read_value,
  output logic [8:0]        entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (CW > 9) ? CW : 9;

  logic [8:0]    capacity;
  logic [2:0]    cmd;
  logic [7:0]    idx;
  logic [31:0]   val;
  logic [CW-1:0] fill;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] wr_ptr;
  logic [31:0]   res;
  logic          keep;
  logic [2:0]    res_status;
  logic [31:0]   rd_val;

  logic [XW-1:0] lim;
  logic          idx_bad;
  logic [2:0]    early_st;
  logic [31:0]   ram_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   prod;
  logic [31:0]   cap_res;
  logic          cap_keep;
  logic          div_done;
  logic [31:0]   div_q;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bale_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    lim     = (XW'(capacity) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(capacity);
    idx_bad = XW'(idx) >= XW'(fill);
    case (cmd)
      bale_pkg::CMD_APPEND: early_st = (XW'(fill) >= lim) ? bale_pkg::ST_FULL : bale_pkg::ST_OK;
      bale_pkg::CMD_READ:   early_st = idx_bad ? bale_pkg::ST_RANGE : bale_pkg::ST_OK;
      bale_pkg::CMD_RMIDX:  early_st = idx_bad ? bale_pkg::ST_RANGE : bale_pkg::ST_OK;
      bale_pkg::CMD_RMVAL:  early_st = (fill == '0) ? bale_pkg::ST_EMPTY : bale_pkg::ST_OK;
      bale_pkg::CMD_DIV:    early_st = (val == '0) ? bale_pkg::ST_DIVZERO : bale_pkg::ST_OK;
      default:              early_st = bale_pkg::ST_OK;
    endcase
  end

  assign prod = ram_rdata * val;

  always_comb begin
    cap_keep = 1'b1;
    case (cmd)
      bale_pkg::CMD_ADD: cap_res = ram_rdata + val;
      bale_pkg::CMD_SUB: cap_res = ($signed(ram_rdata) < $signed(val)) ? '0 : ram_rdata - val;
      bale_pkg::CMD_MUL: cap_res = prod;
      bale_pkg::CMD_RMVAL: begin
        cap_res  = ram_rdata;
        cap_keep = ram_rdata != val;
      end
      default: cap_res = ram_rdata;
    endcase
  end

  always_comb begin
    sts.err       = early_st != bale_pkg::ST_OK;
    sts.is_append = cmd == bale_pkg::CMD_APPEND;
    sts.is_read   = cmd == bale_pkg::CMD_READ;
    sts.is_div    = cmd == bale_pkg::CMD_DIV;
    sts.loop_end  = rd_ptr >= fill;
    sts.div_done  = div_done;
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= command;
      idx <= index;
      val <= value;
    end
    if (ctl.capture) begin
      res  <= cap_res;
      keep <= cap_keep;
    end else if (ctl.div_take) begin
      res  <= div_q;
      keep <= 1'b1;
    end
    if (ctl.decide) begin
      rd_val <= '0;
    end else if (ctl.capture && cmd == bale_pkg::CMD_READ) begin
      rd_val <= ram_rdata;
    end
    if (ctl.decide) begin
      res_status <= early_st;
    end else if (ctl.finish && cmd == bale_pkg::CMD_RMVAL && wr_ptr == fill) begin
      res_status <= bale_pkg::ST_NOTFOUND;
    end
  end

  // count and walk pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      if (ctl.decide) begin
        case (cmd)
          bale_pkg::CMD_READ: begin
            rd_ptr <= CW'(idx);
            wr_ptr <= '0;
          end
          bale_pkg::CMD_RMIDX: begin
            rd_ptr <= CW'(idx) + CW'(1);
            wr_ptr <= CW'(idx);
          end
          default: begin
            rd_ptr <= '0;
            wr_ptr <= '0;
          end
        endcase
      end else if (ctl.write) begin
        rd_ptr <= rd_ptr + CW'(1);
        if (keep) begin
          wr_ptr <= wr_ptr + CW'(1);
        end
      end
      if (ctl.append) begin
        fill <= fill + CW'(1);
      end else if (ctl.finish) begin
        case (cmd)
          bale_pkg::CMD_RMIDX: fill <= fill - CW'(1);
          bale_pkg::CMD_RMVAL: fill <= wr_ptr;
          default:             fill <= fill;
        endcase
      end
    end
  end

  assign ram_we    = ctl.append || (ctl.write && keep);
  assign ram_waddr = ctl.append ? fill[AW-1:0] : wr_ptr[AW-1:0];
  assign ram_wdata = ctl.append ? val : res;

  bale_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_ptr[AW-1:0]),
    .rdata(ram_rdata)
  );

  bale_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (ctl.div_start),
    .dividend(ram_rdata),
    .divisor (val),
    .done    (div_done),
    .quotient(div_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status      <= res_status;
      read_value  <= rd_val;
      entry_count <= 9'(fill);
    end
  end

  `BALE_ASSERT(a_wr_behind_rd, wr_ptr <= rd_ptr, "write pointer ran ahead of read pointer")
  `BALE_ASSERT(a_fill_bound, XW'(fill) <= XW'(DEPTH), "count above depth")
  `BALE_ASSERT(a_append_count, ctl.append |=> fill == $past(fill) + CW'(1), "append lost count")

endmodule

### rtl/bale_ctrl.sv
// list engine controller state machine
module bale_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bale_pkg::dp_sts_t sts,
  output bale_pkg::dp_ctl_t ctl
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_RD     = 8'b0000_0100,
    S_DAT    = 8'b0000_1000,
    S_DIVW   = 8'b0001_0000,
    S_WR     = 8'b0010_0000,
    S_FIN    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = state == S_IDLE;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctl.decide = 1'b1;
        if (sts.err) begin
          state_next = S_DONE;
        end else if (sts.is_append) begin
          ctl.append = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = sts.loop_end ? S_FIN : S_DAT;
      end
      S_DAT: begin
        ctl.capture = 1'b1;
        if (sts.is_read) begin
          state_next = S_DONE;
        end else if (sts.is_div) begin
          ctl.div_start = 1'b1;
          state_next    = S_DIVW;
        end else begin
          state_next = S_WR;
        end
      end
      S_DIVW: begin
        if (sts.div_done) begin
          ctl.div_take = 1'b1;
          state_next   = S_WR;
        end
      end
      S_WR: begin
        ctl.write  = 1'b1;
        state_next = S_RD;
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/bounded_array_list_engine_top.sv
// list engine top level: controller, datapath and configuration port
//
// channel  signals                          direction
// cfg      cfg_valid cfg_ready cfg_data     in  (capacity)
// in       in_valid in_ready command index value   in
// out      out_valid out_ready status read_value entry_count  out
//
// append and failing commands pass through idle, decide and done; read also through rd and dat
// remove, compaction, add, sub, mul: the ram read/write loop of rd, dat and wr per walked entry, then rd, fin, done
// div: as above, with a wait in divw on the one-bit-per-cycle divider for each entry
// synchronous reset empties the list and sets capacity to 256; no clearing pass
// a waiting result sits in the output register while the next item is taken
`include "assert_macros.svh"
module bounded_array_list_engine_top #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [7:0]  index,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] read_value,
  output logic [8:0]  entry_count
);

  bale_pkg::dp_ctl_t ctl;
  bale_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  bale_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .ctl     (ctl)
  );

  bale_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .command    (command),
    .index      (index),
    .value      (value),
    .ctl        (ctl),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_value (read_value),
    .entry_count(entry_count)
  );

  `BALE_ASSERT(a_busy_after_transfer, in_valid && in_ready |=> !in_ready, "took two items back to back")
  `BALE_ASSERT(a_one_item_per_result, ctl.out_load |-> !in_ready, "result loaded while idle")
  `BALE_ASSERT_ALWAYS(a_cfg_open, cfg_ready, "configuration port closed")

endmodule
